/* design/rltd_pkg.sv */
// Shared constants and types for the run-length text decoder.
// No dependencies; used by rltd_ctrl, rltd_dp, run_length_text_decoder_core, rltd_run_checker and tb.
package rltd_pkg;

    // Default saturation limit for a run count
    localparam int MAX_RUN_DEF = 64;

    // ASCII codes and number base of the count text
    localparam logic [7:0] ASCII_ZERO   = 8'd48;
    localparam logic [7:0] ASCII_NINE   = 8'd57;
    localparam logic [7:0] ASCII_DASH   = 8'd45;
    localparam logic [3:0] DECIMAL_BASE = 4'd10;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // input transfer this cycle
        logic step;   // output transfer this cycle
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic close_run;    // current input byte closes a group
        logic run_nonzero;  // the closing group has at least one copy
        logic last_copy;    // the copy on the output is the final one
    } t_stat;

endpackage

/* design/rltd_ctrl.sv */
// Controller state machine for the run-length text decoder.
// Depends on rltd_pkg (t_cmd, t_stat).
module rltd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  rltd_pkg::t_stat i_stat,
    output rltd_pkg::t_cmd  o_cmd
);

    localparam logic ST_PARSE = 1'b0;
    localparam logic ST_EMIT  = 1'b1;

    logic r_state;
    logic n_state;

    assign o_in_ready  = (r_state == ST_PARSE);
    assign o_out_valid = (r_state == ST_EMIT);
    assign o_cmd.load  = i_in_valid & o_in_ready;
    assign o_cmd.step  = o_out_valid & i_out_ready;

    // Next-state logic
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_PARSE: begin
                if (o_cmd.load && i_stat.close_run && i_stat.run_nonzero) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (o_cmd.step && i_stat.last_copy) begin
                    n_state = ST_PARSE;
                end
            end
            default: n_state = ST_PARSE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_PARSE;
        end else begin
            r_state <= n_state;
        end
    end

    // Input and output sides are never open at once
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a copy is pending");

    // A closing group with copies starts the emission in the next cycle
    a_start_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && i_stat.close_run && i_stat.run_nonzero) |=> o_out_valid)
        else $error("run did not start emitting");

    // Transfer of the final copy returns to parsing
    a_end_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step && i_stat.last_copy) |=> (o_in_ready && !o_out_valid))
        else $error("decoder stuck after final copy");

    // A byte that does not close a group with copies leaves the input side open
    a_empty_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && !(i_stat.close_run && i_stat.run_nonzero)) |=> o_in_ready)
        else $error("input stalled after byte without copies");

endmodule

/* design/rltd_dp.sv */
// Datapath of the run-length text decoder: group parsing, count build-up
// with saturation, error flag and the copy counter. Depends on rltd_pkg.
module rltd_dp #(
    parameter int MAX_RUN = rltd_pkg::MAX_RUN_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rltd_pkg::t_cmd  i_cmd,
    input  logic [7:0]      i_in_byte,
    input  logic            i_end_of_string,
    output rltd_pkg::t_stat o_stat,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last,
    output logic            o_run_clipped,
    output logic            o_format_error
);

    localparam int CW = $clog2(MAX_RUN + 1);
    localparam int PW = CW + 4;
    localparam logic [PW-1:0] MAX_P = PW'(MAX_RUN);

    logic          r_in_count;
    logic [7:0]    r_held;
    logic [CW-1:0] r_count;
    logic          r_clip;
    logic          r_err;
    logic [CW-1:0] r_remain;
    logic          r_emit_clip;
    logic          r_emit_err;

    logic          n_in_count;
    logic [CW-1:0] n_count;
    logic          n_clip;
    logic          n_err;
    logic          w_close;
    logic [PW-1:0] w_next;
    logic [3:0]    w_digit;

    // Decimal accumulate of one digit
    assign w_digit = 4'(i_in_byte - rltd_pkg::ASCII_ZERO);
    assign w_next  = PW'(r_count) * PW'(rltd_pkg::DECIMAL_BASE) + PW'(w_digit);

    // Parse one byte
    always_comb begin
        n_in_count = r_in_count;
        n_count    = r_count;
        n_clip     = r_clip;
        n_err      = r_err;
        w_close    = 1'b0;
        if (!r_in_count) begin
            n_count    = '0;
            n_clip     = 1'b0;
            n_in_count = 1'b1;
            w_close    = i_end_of_string;
        end else begin
            if (i_in_byte == rltd_pkg::ASCII_DASH) begin
                w_close = 1'b1;
            end else if (i_in_byte inside {[rltd_pkg::ASCII_ZERO:rltd_pkg::ASCII_NINE]}) begin
                if (w_next > MAX_P) begin
                    n_count = CW'(MAX_RUN);
                    n_clip  = 1'b1;
                end else begin
                    n_count = w_next[CW-1:0];
                end
            end else begin
                n_err = 1'b1;
            end
            if (i_end_of_string) begin
                w_close = 1'b1;
            end
        end
    end

    assign o_stat.close_run   = w_close;
    assign o_stat.run_nonzero = (n_count != '0);
    assign o_stat.last_copy   = (r_remain == CW'(1));

    // Parser state and copy counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_count  <= 1'b0;
            r_held      <= '0;
            r_count     <= '0;
            r_clip      <= 1'b0;
            r_err       <= 1'b0;
            r_remain    <= '0;
            r_emit_clip <= 1'b0;
            r_emit_err  <= 1'b0;
        end else if (i_cmd.load) begin
            if (!r_in_count) begin
                r_held <= i_in_byte;
            end
            r_err <= i_end_of_string ? 1'b0 : n_err;
            if (w_close) begin
                r_in_count  <= 1'b0;
                r_count     <= '0;
                r_clip      <= 1'b0;
                r_remain    <= n_count;
                r_emit_clip <= n_clip;
                r_emit_err  <= n_err;
            end else begin
                r_in_count <= n_in_count;
                r_count    <= n_count;
                r_clip     <= n_clip;
            end
        end else if (i_cmd.step) begin
            r_remain <= r_remain - CW'(1);
        end
    end

    assign o_out_byte     = r_held;
    assign o_run_last     = o_stat.last_copy;
    assign o_run_clipped  = r_emit_clip;
    assign o_format_error = r_emit_err;

    // Count never passes the saturation limit
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CW'(MAX_RUN)) && (r_remain <= CW'(MAX_RUN)))
        else $error("run count above limit");

    // Each copy transfer takes one off the remaining count
    a_countdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !i_cmd.load) |=> (r_remain == $past(r_remain) - CW'(1)))
        else $error("copy counter did not step");

    // Clip flag only with a saturated count
    a_clip_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clip |-> (r_count == CW'(MAX_RUN)))
        else $error("clip flag without saturated count");

endmodule

/* design/run_length_text_decoder_core.sv */
// Run-length text decoder: one input byte per transfer, one run copy per output transfer.
// The first copy of a run is valid in the cycle after the closing byte's transfer.
// A byte that emits nothing leaves the input side ready; a closing byte with count N holds
// the input side off until the copy counter has emitted N copies, one copy per cycle while i_out_ready is high.
// Reset (i_rst_n low, synchronous): parser waits for a symbol, count and flags cleared.
// Depends on rltd_pkg, rltd_ctrl and rltd_dp.
module run_length_text_decoder_core #(
    parameter int MAX_RUN = rltd_pkg::MAX_RUN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_string,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_run_clipped,
    output logic       o_format_error
);

    rltd_pkg::t_cmd  w_cmd;
    rltd_pkg::t_stat w_stat;

    // Sequencer
    rltd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Parser and copy counter
    rltd_dp #(
        .MAX_RUN (MAX_RUN)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .o_stat          (w_stat),
        .o_out_byte      (o_out_byte),
        .o_run_last      (o_run_last),
        .o_run_clipped   (o_run_clipped),
        .o_format_error  (o_format_error)
    );

endmodule

/* verif/rltd_run_checker.sv */
// Checker for the run-length text decoder: watches both channels, predicts every copy and
// compares each output transfer with the oldest expected copy. Depends on rltd_pkg.
`timescale 1ns / 100ps

module rltd_run_checker #(
    parameter int MAX_RUN = rltd_pkg::MAX_RUN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_string,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_run_last,
    input  logic       i_run_clipped,
    input  logic       i_format_error,
    output int         o_fail_count,
    output int         o_copies_pending
);

    // one expected copy of a run symbol
    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
        logic       clipped;
        logic       fmt_err;
    } t_copy;

    t_copy copies_q[$];

    // parser state of the prediction
    logic       count_phase;
    logic [7:0] run_sym;
    logic [6:0] run_len;
    logic       len_clipped;
    logic       fmt_err;

    initial begin
        o_fail_count     = 0;
        o_copies_pending = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic clear_parser();
        count_phase = 1'b0;
        run_sym     = '0;
        run_len     = '0;
        len_clipped = 1'b0;
        fmt_err     = 1'b0;
    endtask

    // Parse one text byte and queue the copies that closing a group emits
    task automatic decode_byte(input logic [7:0] b, input logic eos);
        int   next;
        logic close;
        close = 1'b0;
        if (!count_phase) begin
            // first byte of a group is always the symbol
            run_sym     = b;
            run_len     = '0;
            len_clipped = 1'b0;
            count_phase = 1'b1;
            close       = eos;
        end else begin
            if (b == rltd_pkg::ASCII_DASH) begin
                close = 1'b1;
            end else if (b >= rltd_pkg::ASCII_ZERO && b <= rltd_pkg::ASCII_NINE) begin
                next = int'(run_len) * int'(rltd_pkg::DECIMAL_BASE)
                     + int'(b) - int'(rltd_pkg::ASCII_ZERO);
                if (next > MAX_RUN) begin
                    run_len     = 7'(MAX_RUN);
                    len_clipped = 1'b1;
                end else begin
                    run_len = 7'(next);
                end
            end else begin
                fmt_err = 1'b1;
            end
            if (eos)
                close = 1'b1;
        end
        if (close) begin
            for (int k = 0; k < int'(run_len); k++)
                copies_q.push_back('{run_sym, (k == int'(run_len) - 1), len_clipped, fmt_err});
            count_phase = 1'b0;
            run_len     = '0;
            len_clipped = 1'b0;
        end
        // error flag is sticky until end of string
        if (eos)
            fmt_err = 1'b0;
    endtask

    initial clear_parser();

    // Sample both channels at the rising edge; input side first so a copy never
    // overtakes the byte that produced it
    always @(posedge i_clk) begin
        t_copy exp_copy;
        if (!i_rst_n) begin
            clear_parser();
            copies_q.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                decode_byte(i_in_byte, i_end_of_string);
            if (i_out_valid && i_out_ready) begin
                if (copies_q.size() == 0) begin
                    report_mismatch($sformatf("copy 0x%02h with nothing expected", i_out_byte));
                end else begin
                    exp_copy = copies_q.pop_front();
                    if (i_out_byte !== exp_copy.symbol)
                        report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                                  i_out_byte, exp_copy.symbol));
                    if (i_run_last !== exp_copy.last)
                        report_mismatch($sformatf("run_last %b, expected %b",
                                                  i_run_last, exp_copy.last));
                    if (i_run_clipped !== exp_copy.clipped)
                        report_mismatch($sformatf("run_clipped %b, expected %b",
                                                  i_run_clipped, exp_copy.clipped));
                    if (i_format_error !== exp_copy.fmt_err)
                        report_mismatch($sformatf("format_error %b, expected %b",
                                                  i_format_error, exp_copy.fmt_err));
                end
            end
        end
        o_copies_pending = copies_q.size();
    end

endmodule

/* verif/tb.sv */
// Top of the run-length text decoder testbench: clock, reset, text stimulus and receiver
// stalls, verdict. Depends on rltd_pkg, run_length_text_decoder_core and rltd_run_checker.
`timescale 1ns / 100ps

module tb;

    localparam int MAX_RUN = rltd_pkg::MAX_RUN_DEF;

    // receiver stall patterns
    localparam int RX_ALWAYS   = 0;
    localparam int RX_MOSTLY   = 1;
    localparam int RX_PERIODIC = 2;
    localparam int RX_RANDOM   = 3;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } t_text_byte;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_in_byte;
    logic       i_end_of_string;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_byte;
    logic       o_run_last;
    logic       o_run_clipped;
    logic       o_format_error;

    int fail_count;
    int copies_pending;

    t_text_byte text_q[$];
    int         burst_left;
    bit         sender_gaps;
    int         rx_mode;
    bit         hold_off_req;

    run_length_text_decoder_core #(.MAX_RUN(MAX_RUN)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_run_last      (o_run_last),
        .o_run_clipped   (o_run_clipped),
        .o_format_error  (o_format_error)
    );

    rltd_run_checker #(.MAX_RUN(MAX_RUN)) run_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_in_byte        (i_in_byte),
        .i_end_of_string  (i_end_of_string),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_out_byte       (o_out_byte),
        .i_run_last       (o_run_last),
        .i_run_clipped    (o_run_clipped),
        .i_format_error   (o_format_error),
        .o_fail_count     (fail_count),
        .o_copies_pending (copies_pending)
    );

    // 20 ns clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // hard stop
    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: stall pattern per mode, plus one long hold-off on request
    initial begin
        int cyc;
        cyc         = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (250) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                case (rx_mode)
                    RX_MOSTLY:   i_out_ready <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: i_out_ready <= ((cyc % 7) >= 2);
                    RX_RANDOM:   i_out_ready <= 1'($urandom_range(0, 1));
                    default:     i_out_ready <= 1'b1;
                endcase
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic eos);
        text_q.push_back('{b, eos});
    endtask

    task automatic push_text(input string s, input bit eos_last);
        foreach (s[i])
            push_byte(s[i], eos_last && (i == s.len() - 1));
    endtask

    // One group with random content; some are malformed on purpose
    task automatic queue_group(input bit long_runs);
        logic [7:0] sym;
        logic [7:0] noise;
        int         run_len;
        int         pick;
        int         ending;
        bit         eos_on_digit;
        string      digits;
        sym  = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (long_runs)
            run_len = $urandom_range(30, 70);
        else if (pick < 70)
            run_len = $urandom_range(0, 9);
        else if (pick < 88)
            run_len = $urandom_range(10, 40);
        else if (pick < 95)
            run_len = $urandom_range(41, 64);
        else
            run_len = $urandom_range(65, 999);
        // symbol that ends the string: empty run
        if ($urandom_range(0, 19) == 0) begin
            push_byte(sym, 1'b1);
            return;
        end
        push_byte(sym, 1'b0);
        digits = $sformatf("%0d", run_len);
        if ($urandom_range(0, 9) == 0)
            digits = {"0", digits};
        if ($urandom_range(0, 14) == 0)
            digits = "";
        ending       = $urandom_range(0, 9);
        eos_on_digit = (ending == 8) && (digits.len() > 0);
        foreach (digits[i]) begin
            if ($urandom_range(0, 24) == 0) begin
                do noise = 8'($urandom);
                while ((noise >= rltd_pkg::ASCII_ZERO && noise <= rltd_pkg::ASCII_NINE) ||
                       noise == rltd_pkg::ASCII_DASH);
                push_byte(noise, 1'b0);
            end
            push_byte(digits[i], eos_on_digit && (i == digits.len() - 1));
        end
        if (!eos_on_digit)
            push_byte(rltd_pkg::ASCII_DASH, ending == 7);
    endtask

    task automatic queue_groups(input int n_bytes, input bit long_runs);
        int target;
        target = text_q.size() + n_bytes;
        while (text_q.size() < target)
            queue_group(long_runs);
    endtask

    // Drive queued bytes in bursts; valid holds until each transfer
    task automatic send_text();
        t_text_byte tb_item;
        int         gap;
        while (text_q.size() > 0) begin
            tb_item = text_q.pop_front();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 10);
                gap        = sender_gaps ? $urandom_range(0, 5) : 0;
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    i_in_byte  <= 8'($urandom);
                    repeat (gap) @(negedge i_clk);
                end
            end
            i_in_valid      <= 1'b1;
            i_in_byte       <= tb_item.data;
            i_end_of_string <= tb_item.eos;
            do @(posedge i_clk); while (!o_in_ready);
            @(negedge i_clk);
            burst_left--;
        end
        i_in_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in_byte       = '0;
        i_end_of_string = 1'b0;
        burst_left      = 0;
        sender_gaps     = 1'b1;
        rx_mode         = RX_MOSTLY;
        hold_off_req    = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes of symbol and count, dash symbol, empty runs, error flag
        push_text("a7-", 1'b0);
        push_byte(8'h00, 1'b0);
        push_text("64-", 1'b0);     // count at the limit, not clipped
        push_byte(8'hFF, 1'b0);
        push_text("65", 1'b1);      // clipped, closed by a digit at end of string
        push_text("-3-", 1'b0);     // dash taken as the symbol
        push_text("q", 1'b1);       // symbol at end of string emits nothing
        push_text("k-", 1'b0);      // empty count
        push_text("e2x1-", 1'b0);   // stray byte in the count sets the error flag
        push_text("f2-", 1'b1);     // flag still set, dash at end of string clears it
        push_text("g1Z", 1'b1);     // stray byte at end of string still closes the group
        send_text();

        // random stalls on the receiver
        rx_mode = RX_RANDOM;
        queue_groups(45, 1'b0);
        send_text();

        // long runs while the receiver holds off, so the input side backs up
        rx_mode      = RX_ALWAYS;
        hold_off_req = 1'b1;
        queue_groups(20, 1'b1);
        send_text();

        // periodic receiver stalls
        rx_mode = RX_PERIODIC;
        queue_groups(45, 1'b0);
        send_text();

        // no idling on either side
        rx_mode     = RX_ALWAYS;
        sender_gaps = 1'b0;
        queue_groups(40, 1'b0);
        send_text();

        // drain and let any late copy show up
        while (copies_pending != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && copies_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
design/rltd_pkg.sv
design/rltd_ctrl.sv
design/rltd_dp.sv
design/run_length_text_decoder_core.sv
verif/rltd_run_checker.sv
verif/tb.sv
